// ===== rtl/core/pcot_pkg.sv =====
// Package with widths, codes and shared types for the polygon/circle overlap test.
package pcot_pkg;

   localparam int COORD_BITS = 16;
   localparam int CIRCLE_W   = 16;
   localparam int RADIUS_W   = 15;
   localparam int ABS_W      = COORD_BITS + 1;
   localparam int DIFF_W     = ((ABS_W > CIRCLE_W) ? ABS_W : CIRCLE_W) + 1;
   localparam int CHUNK_W    = DIFF_W;
   localparam int MUL_W      = CHUNK_W + 1;
   localparam int PROD_W     = 2 * MUL_W;
   localparam int WIDE_W     = 2 * CHUNK_W;
   localparam int ACC_W      = 4 * CHUNK_W + 2;
   localparam int R2_W       = 2 * RADIUS_W;
   localparam int REQ_W      = ((4 * COORD_BITS + 7) / 8) * 8;
   localparam int RSP_W      = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CIRCLE_X = 2'd0,
      CSR_CIRCLE_Y = 2'd1,
      CSR_RADIUS   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ADD,
      OP_SUB
   } mac_op_type;

   typedef enum logic [1:0] {
      SH_NONE,
      SH_CHUNK,
      SH_CHUNK1,
      SH_CHUNK2
   } mac_shift_type;

   typedef struct packed {
      logic          en;
      mac_op_type    op;
      mac_shift_type sh;
   } mac_ctrl_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_R2,
      ST_LEN0,
      ST_LEN1,
      ST_DOT0,
      ST_DOT1,
      ST_PICK,
      ST_END0,
      ST_END1,
      ST_ENDCMP,
      ST_CR0,
      ST_CR1,
      ST_ABS,
      ST_SQ0,
      ST_SQ1,
      ST_SQ2,
      ST_RL0,
      ST_RL1,
      ST_RL2,
      ST_RL3,
      ST_CMP,
      ST_EMIT
   } state_type;

endpackage

// ===== rtl/core/pcot_mac.sv =====
// Shared signed multiply-accumulate unit with a selectable left shift of the product.
module pcot_mac
   import pcot_pkg::*;
(
   input  logic                    clock,
   input  mac_ctrl_type            ctrl,
   input  logic signed [MUL_W-1:0] op_a,
   input  logic signed [MUL_W-1:0] op_b,
   output logic signed [ACC_W-1:0] acc
);

   logic signed [PROD_W-1:0] prod;
   logic signed [ACC_W-1:0]  prod_ext;
   logic signed [ACC_W-1:0]  shifted;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;

   assign prod     = op_a * op_b;
   assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

   always_comb begin
      case (ctrl.sh)
         SH_NONE:   shifted = prod_ext;
         SH_CHUNK:  shifted = prod_ext <<< CHUNK_W;
         SH_CHUNK1: shifted = prod_ext <<< (CHUNK_W + 1);
         SH_CHUNK2: shifted = prod_ext <<< (2 * CHUNK_W);
         default:   shifted = prod_ext;
      endcase
   end

   always_comb begin
      acc_in = acc_ff;
      if (ctrl.en) begin
         case (ctrl.op)
            OP_LOAD: acc_in = shifted;
            OP_ADD:  acc_in = acc_ff + shifted;
            OP_SUB:  acc_in = acc_ff - shifted;
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ===== rtl/core/polygon_circle_overlap_test_top.sv =====
// Top level of the polygon/circle overlap test: vertex intake, edge sequencer and result register.
//
//   channel  direction  transfer when            carries
//   req      in         req_tvalid & req_tready  one polygon vertex, tlast on the final one
//   rsp      out        rsp_tvalid & rsp_tready  hit flag, one per polygon
//   csr      in         csr_we                   circle centre and radius
//
// Each edge runs on the one shared multiply-accumulate unit, on a shorter state path when the
// nearest point is an endpoint than when it lies inside the segment.
// A vertex is taken in the idle state and, from the second one on, starts one edge test; the
// final vertex adds the closing edge if there are two or more, then the emit state loads the result register.
// Reset is synchronous and clears the sequencer, polygon tracking, circle registers and response valid flag.
// A result held by rsp_tready = 0 stalls only the final vertex of the next polygon.
module polygon_circle_overlap_test_top
   import pcot_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vertex_x, vertex_y, shape_x, shape_y
   input  logic [REQ_W-1:0]      req_tdata,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // hit
   output logic [RSP_W-1:0]      rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   state_type state_ff, state_in;

   logic signed [CIRCLE_W-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic [RADIUS_W-1:0]        rad_ff, rad_in;

   logic have_first_ff, have_first_in;
   logic hit_seen_ff, hit_seen_in;
   logic last_ff, last_in;
   logic closing_ff, closing_in;
   logic endpoint_ff, endpoint_in;
   logic use_b_ff, use_b_in;
   logic res_ff, res_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_hit_ff, rsp_hit_in;

   logic signed [ABS_W-1:0]  first_x_ff, first_x_in, first_y_ff, first_y_in;
   logic signed [ABS_W-1:0]  prev_x_ff, prev_x_in, prev_y_ff, prev_y_in;
   logic signed [ABS_W-1:0]  ea_x_ff, ea_x_in, ea_y_ff, ea_y_in;
   logic signed [ABS_W-1:0]  eb_x_ff, eb_x_in, eb_y_ff, eb_y_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic signed [DIFF_W-1:0] fx_ff, fx_in, fy_ff, fy_in;
   logic signed [DIFF_W-1:0] gx_ff, gx_in, gy_ff, gy_in;
   logic [R2_W-1:0]          r2_ff, r2_in;
   logic [WIDE_W-1:0]        len2_ff, len2_in;
   logic [WIDE_W-1:0]        c_ff, c_in;
   logic signed [ACC_W-1:0]  c2_ff, c2_in;

   logic                    req_fire;
   logic signed [ABS_W-1:0] px, py;
   logic signed [ACC_W-1:0] acc;
   logic signed [ACC_W-1:0] acc_neg;
   logic signed [ACC_W-1:0] len2_ext;
   logic signed [ACC_W-1:0] r2_ext;
   logic [WIDE_W-1:0]       r2_wide;
   logic                    near_a, near_b;
   logic                    edge_hit;
   logic                    edge_done;

   mac_ctrl_type            mac_ctrl;
   logic signed [MUL_W-1:0] op_a, op_b;

   pcot_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .op_a  (op_a),
      .op_b  (op_b),
      .acc   (acc)
   );

   // Absolute vertex: offset plus polygon centre, one bit wider.
   assign px = ABS_W'($signed(req_tdata[COORD_BITS-1:0]))
             + ABS_W'($signed(req_tdata[3*COORD_BITS-1:2*COORD_BITS]));
   assign py = ABS_W'($signed(req_tdata[2*COORD_BITS-1:COORD_BITS]))
             + ABS_W'($signed(req_tdata[4*COORD_BITS-1:3*COORD_BITS]));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign acc_neg  = -acc;
   assign len2_ext = ACC_W'($signed({1'b0, len2_ff}));
   assign r2_ext   = ACC_W'($signed({1'b0, r2_ff}));
   assign r2_wide  = WIDE_W'(r2_ff);
   assign near_a   = (len2_ff == '0) || (acc <= 0);
   assign near_b   = (acc >= len2_ext);

   always_comb begin
      state_in      = state_ff;
      cx_in         = cx_ff;
      cy_in         = cy_ff;
      rad_in        = rad_ff;
      have_first_in = have_first_ff;
      hit_seen_in   = hit_seen_ff;
      last_in       = last_ff;
      closing_in    = closing_ff;
      endpoint_in   = endpoint_ff;
      use_b_in      = use_b_ff;
      res_in        = res_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_hit_in    = rsp_hit_ff;
      first_x_in    = first_x_ff;
      first_y_in    = first_y_ff;
      prev_x_in     = prev_x_ff;
      prev_y_in     = prev_y_ff;
      ea_x_in       = ea_x_ff;
      ea_y_in       = ea_y_ff;
      eb_x_in       = eb_x_ff;
      eb_y_in       = eb_y_ff;
      dx_in         = dx_ff;
      dy_in         = dy_ff;
      fx_in         = fx_ff;
      fy_in         = fy_ff;
      gx_in         = gx_ff;
      gy_in         = gy_ff;
      r2_in         = r2_ff;
      len2_in       = len2_ff;
      c_in          = c_ff;
      c2_in         = c2_ff;
      mac_ctrl      = '{en: 1'b0, op: OP_LOAD, sh: SH_NONE};
      op_a          = '0;
      op_b          = '0;
      edge_hit      = 1'b0;
      edge_done     = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_CIRCLE_X: cx_in  = $signed(csr_wdata[CIRCLE_W-1:0]);
            CSR_CIRCLE_Y: cy_in  = $signed(csr_wdata[CIRCLE_W-1:0]);
            CSR_RADIUS:   rad_in = csr_wdata[RADIUS_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               prev_x_in  = px;
               prev_y_in  = py;
               last_in    = req_tlast;
               closing_in = 1'b0;
               if (!have_first_ff) begin
                  first_x_in    = px;
                  first_y_in    = py;
                  have_first_in = 1'b1;
                  if (req_tlast) begin
                     res_in   = 1'b0;
                     state_in = ST_EMIT;
                  end
               end else begin
                  ea_x_in    = prev_x_ff;
                  ea_y_in    = prev_y_ff;
                  eb_x_in    = px;
                  eb_y_in    = py;
                  state_in   = ST_R2;
               end
            end
         end
         ST_R2: begin
            dx_in    = DIFF_W'(eb_x_ff) - DIFF_W'(ea_x_ff);
            dy_in    = DIFF_W'(eb_y_ff) - DIFF_W'(ea_y_ff);
            fx_in    = DIFF_W'(cx_ff) - DIFF_W'(ea_x_ff);
            fy_in    = DIFF_W'(cy_ff) - DIFF_W'(ea_y_ff);
            gx_in    = DIFF_W'(cx_ff) - DIFF_W'(eb_x_ff);
            gy_in    = DIFF_W'(cy_ff) - DIFF_W'(eb_y_ff);
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = $signed({{(MUL_W-RADIUS_W){1'b0}}, rad_ff});
            op_b     = $signed({{(MUL_W-RADIUS_W){1'b0}}, rad_ff});
            state_in = ST_LEN0;
         end
         ST_LEN0: begin
            r2_in    = acc[R2_W-1:0];
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = MUL_W'(dx_ff);
            op_b     = MUL_W'(dx_ff);
            state_in = ST_LEN1;
         end
         ST_LEN1: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_NONE};
            op_a     = MUL_W'(dy_ff);
            op_b     = MUL_W'(dy_ff);
            state_in = ST_DOT0;
         end
         ST_DOT0: begin
            len2_in  = acc[WIDE_W-1:0];
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = MUL_W'(fx_ff);
            op_b     = MUL_W'(dx_ff);
            state_in = ST_DOT1;
         end
         ST_DOT1: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_NONE};
            op_a     = MUL_W'(fy_ff);
            op_b     = MUL_W'(dy_ff);
            state_in = ST_PICK;
         end
         ST_PICK: begin
            // The accumulator holds the projection of the centre onto the edge.
            endpoint_in = near_a || near_b;
            use_b_in    = !near_a && near_b;
            state_in    = (near_a || near_b) ? ST_END0 : ST_CR0;
         end
         ST_END0: begin
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = use_b_ff ? MUL_W'(gx_ff) : MUL_W'(fx_ff);
            op_b     = op_a;
            state_in = ST_END1;
         end
         ST_END1: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_NONE};
            op_a     = use_b_ff ? MUL_W'(gy_ff) : MUL_W'(fy_ff);
            op_b     = op_a;
            state_in = ST_ENDCMP;
         end
         ST_ENDCMP: begin
            edge_hit  = (acc <= r2_ext);
            edge_done = 1'b1;
         end
         ST_CR0: begin
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = MUL_W'(dx_ff);
            op_b     = MUL_W'(fy_ff);
            state_in = ST_CR1;
         end
         ST_CR1: begin
            mac_ctrl = '{en: 1'b1, op: OP_SUB, sh: SH_NONE};
            op_a     = MUL_W'(dy_ff);
            op_b     = MUL_W'(fx_ff);
            state_in = ST_ABS;
         end
         ST_ABS: begin
            c_in     = acc[ACC_W-1] ? acc_neg[WIDE_W-1:0] : acc[WIDE_W-1:0];
            state_in = ST_SQ0;
         end
         // Square of the cross product from two chunks: lo*lo + 2*hi*lo + hi*hi.
         ST_SQ0: begin
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = $signed({1'b0, c_ff[CHUNK_W-1:0]});
            op_b     = $signed({1'b0, c_ff[CHUNK_W-1:0]});
            state_in = ST_SQ1;
         end
         ST_SQ1: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_CHUNK1};
            op_a     = $signed({1'b0, c_ff[WIDE_W-1:CHUNK_W]});
            op_b     = $signed({1'b0, c_ff[CHUNK_W-1:0]});
            state_in = ST_SQ2;
         end
         ST_SQ2: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_CHUNK2};
            op_a     = $signed({1'b0, c_ff[WIDE_W-1:CHUNK_W]});
            op_b     = $signed({1'b0, c_ff[WIDE_W-1:CHUNK_W]});
            state_in = ST_RL0;
         end
         // Squared radius times squared edge length, four partial products.
         ST_RL0: begin
            c2_in    = acc;
            mac_ctrl = '{en: 1'b1, op: OP_LOAD, sh: SH_NONE};
            op_a     = $signed({1'b0, r2_wide[CHUNK_W-1:0]});
            op_b     = $signed({1'b0, len2_ff[CHUNK_W-1:0]});
            state_in = ST_RL1;
         end
         ST_RL1: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_CHUNK};
            op_a     = $signed({1'b0, r2_wide[CHUNK_W-1:0]});
            op_b     = $signed({1'b0, len2_ff[WIDE_W-1:CHUNK_W]});
            state_in = ST_RL2;
         end
         ST_RL2: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_CHUNK};
            op_a     = $signed({1'b0, r2_wide[WIDE_W-1:CHUNK_W]});
            op_b     = $signed({1'b0, len2_ff[CHUNK_W-1:0]});
            state_in = ST_RL3;
         end
         ST_RL3: begin
            mac_ctrl = '{en: 1'b1, op: OP_ADD, sh: SH_CHUNK2};
            op_a     = $signed({1'b0, r2_wide[WIDE_W-1:CHUNK_W]});
            op_b     = $signed({1'b0, len2_ff[WIDE_W-1:CHUNK_W]});
            state_in = ST_CMP;
         end
         ST_CMP: begin
            edge_hit  = (c2_ff <= acc);
            edge_done = 1'b1;
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_ff;
               hit_seen_in   = 1'b0;
               have_first_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (edge_done) begin
         if (closing_ff) begin
            res_in   = hit_seen_ff || edge_hit;
            state_in = ST_EMIT;
         end else if (last_ff) begin
            // Closing edge runs from the final vertex back to the first one.
            hit_seen_in = hit_seen_ff || edge_hit;
            ea_x_in     = prev_x_ff;
            ea_y_in     = prev_y_ff;
            eb_x_in     = first_x_ff;
            eb_y_in     = first_y_ff;
            closing_in  = 1'b1;
            state_in    = ST_R2;
         end else begin
            hit_seen_in = hit_seen_ff || edge_hit;
            state_in    = ST_IDLE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         cx_ff         <= '0;
         cy_ff         <= '0;
         rad_ff        <= '0;
         have_first_ff <= 1'b0;
         hit_seen_ff   <= 1'b0;
         last_ff       <= 1'b0;
         closing_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         cx_ff         <= cx_in;
         cy_ff         <= cy_in;
         rad_ff        <= rad_in;
         have_first_ff <= have_first_in;
         hit_seen_ff   <= hit_seen_in;
         last_ff       <= last_in;
         closing_ff    <= closing_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      endpoint_ff <= endpoint_in;
      use_b_ff    <= use_b_in;
      res_ff      <= res_in;
      rsp_hit_ff  <= rsp_hit_in;
      first_x_ff  <= first_x_in;
      first_y_ff  <= first_y_in;
      prev_x_ff   <= prev_x_in;
      prev_y_ff   <= prev_y_in;
      ea_x_ff     <= ea_x_in;
      ea_y_ff     <= ea_y_in;
      eb_x_ff     <= eb_x_in;
      eb_y_ff     <= eb_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      fx_ff       <= fx_in;
      fy_ff       <= fy_in;
      gx_ff       <= gx_in;
      gy_ff       <= gy_in;
      r2_ff       <= r2_in;
      len2_ff     <= len2_in;
      c_ff        <= c_in;
      c2_ff       <= c2_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_W-1){1'b0}}, rsp_hit_ff};

   // A new result appears only out of the emit state.
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EMIT && !rsp_valid_ff) |=> !rsp_valid_ff)
      else $error("result raised outside the emit state");

   // The closing edge is only ever tested for the final vertex.
   a_closing_last: assert property (@(posedge clock) disable iff (reset)
      closing_ff |-> last_ff)
      else $error("closing edge without a final vertex");

   // The interior path is taken only when the projection check chose it.
   a_interior_path: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CR0) |-> !endpoint_ff)
      else $error("cross product started for an endpoint case");

   // A vertex that is not the final one never produces a result directly.
   a_no_early_emit: assert property (@(posedge clock) disable iff (reset)
      (req_fire && !req_tlast) |=> (state_ff != ST_EMIT))
      else $error("result scheduled for a non-final vertex");

endmodule
